FILE: hdl/frame_escape_xor_checksum_defines.svh
// Assertion macros for the frame escaper with XOR checksum.
// Included by the top level; no other dependencies.
`ifndef FRAME_ESCAPE_XOR_CHECKSUM_DEFINES_SVH
`define FRAME_ESCAPE_XOR_CHECKSUM_DEFINES_SVH
`ifndef SYNTHESIS
`define FEXC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fexc assertion failed");
`define FEXC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fexc implication failed");
`else
`define FEXC_ASSERT(lbl, clk, rstn, prop)
`define FEXC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/fexc_pkg.sv
// Shared types, constants and helpers for the frame escaper.
// No dependencies.
package fexc_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7e;
    localparam logic [7:0] ESC_BYTE    = 8'h7d;
    localparam logic [7:0] ESC_OF_FLAG = 8'h02;
    localparam logic [7:0] ESC_OF_ESC  = 8'h01;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified input byte, waiting to be expanded into output bytes.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_esc;
        logic       frame_last;
        logic [7:0] csum;
        logic       csum_esc;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_rd_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] escape_code(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_OF_FLAG : ESC_OF_ESC;
    endfunction

endpackage

FILE: hdl/fexc_front.sv
// Front end: accepts input bytes, tracks frame start and running checksum,
// and pushes a classified descriptor to the queue. Depends on fexc_pkg.
module fexc_front import fexc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // frame_last
    input  logic       q_full,
    output q_wr_t      q_wr
);

    logic [7:0] csum_reg, csum_next;
    logic       at_start_reg, at_start_next;
    logic       accept;
    logic [7:0] csum_new;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Head byte restarts the sum and is not included.
    assign csum_new = at_start_reg ? 8'h00 : (csum_reg ^ s_tdata);

    always_comb begin
        csum_next     = csum_reg;
        at_start_next = at_start_reg;
        if (accept) begin
            csum_next     = s_tlast ? 8'h00 : csum_new;
            at_start_next = s_tlast;
        end
    end

    always_comb begin
        q_wr.push            = accept;
        q_wr.desc.data_byte  = s_tdata;
        q_wr.desc.data_esc   = !at_start_reg && needs_escape(s_tdata);
        q_wr.desc.frame_last = s_tlast;
        q_wr.desc.csum       = csum_new;
        q_wr.desc.csum_esc   = needs_escape(csum_new);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csum_reg     <= 8'h00;
            at_start_reg <= 1'b1;
        end else begin
            csum_reg     <= csum_next;
            at_start_reg <= at_start_next;
        end
    end

endmodule

FILE: hdl/fexc_queue.sv
// Short descriptor queue between front and back end.
// Depends on fexc_pkg.
module fexc_queue import fexc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t q_wr,
    input  logic  pop,
    output logic  full,
    output q_rd_t q_rd
);

    desc_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.desc  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({q_wr.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem[wr_ptr_reg] <= q_wr.desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/fexc_back.sv
// Back end: expands the head descriptor into escaped output bytes, one per
// cycle unless m_tready stalls, into a registered output stage. Depends on fexc_pkg.
module fexc_back import fexc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  q_rd_t      q_rd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // frame_end
);

    typedef enum logic [4:0] {
        ST_DATA      = 5'b00001,
        ST_DATA_ESC2 = 5'b00010,
        ST_CSUM      = 5'b00100,
        ST_CSUM_ESC2 = 5'b01000,
        ST_FLAG      = 5'b10000
    } step_t;

    step_t      step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;
    logic       load;
    logic [7:0] byte_sel;
    logic       done_sel;
    logic       fend_sel;
    step_t      step_adv;

    assign load = q_rd.valid && (!m_tvalid_reg || m_tready);
    assign pop  = load && done_sel;

    always_comb begin
        byte_sel = q_rd.desc.data_byte;
        done_sel = 1'b0;
        fend_sel = 1'b0;
        step_adv = ST_DATA;
        unique case (step_reg)
            ST_DATA: begin
                byte_sel = q_rd.desc.data_esc ? ESC_BYTE : q_rd.desc.data_byte;
                done_sel = !q_rd.desc.data_esc && !q_rd.desc.frame_last;
                if (q_rd.desc.data_esc) begin
                    step_adv = ST_DATA_ESC2;
                end else if (q_rd.desc.frame_last) begin
                    step_adv = ST_CSUM;
                end else begin
                    step_adv = ST_DATA;
                end
            end
            ST_DATA_ESC2: begin
                byte_sel = escape_code(q_rd.desc.data_byte);
                done_sel = !q_rd.desc.frame_last;
                step_adv = q_rd.desc.frame_last ? ST_CSUM : ST_DATA;
            end
            ST_CSUM: begin
                byte_sel = q_rd.desc.csum_esc ? ESC_BYTE : q_rd.desc.csum;
                step_adv = q_rd.desc.csum_esc ? ST_CSUM_ESC2 : ST_FLAG;
            end
            ST_CSUM_ESC2: begin
                byte_sel = escape_code(q_rd.desc.csum);
                step_adv = ST_FLAG;
            end
            ST_FLAG: begin
                byte_sel = FLAG_BYTE;
                done_sel = 1'b1;
                fend_sel = 1'b1;
                step_adv = ST_DATA;
            end
            default: begin
                byte_sel = q_rd.desc.data_byte;
                done_sel = 1'b0;
                fend_sel = 1'b0;
                step_adv = ST_DATA;
            end
        endcase
    end

    always_comb begin
        step_next     = load ? step_adv : step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_DATA;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload: load only when the output stage is free or being drained.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= done_sel;
            m_tuser_reg <= fend_sel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hdl/frame_escape_xor_checksum.sv
// Frame escaper with XOR checksum: byte-stuffs a frame and appends checksum.
//
// Input channel s_*: one raw frame byte per transfer, s_tlast on the final
// byte. The first byte of a frame passes unchanged and is not summed; every
// later byte is XORed into the checksum and escaped (0x7e -> 0x7d 0x02,
// 0x7d -> 0x7d 0x01). After the final byte the escaped checksum and a
// closing 0x7e follow.
// Output channel m_*: one encoded byte per transfer. m_tlast marks the last
// byte caused by one input transfer, m_tuser the closing 0x7e.
// The first output byte of an input passes through the queue entry and then
// the output register before it is offered on m_*. Throughput: one output
// byte per cycle while m_tready is high; an input causes 1 to 5 output bytes,
// which all leave through the single output register.
// A two-entry queue lets the input side keep accepting while output drains.
// Reset clears the checksum, marks the next byte as a frame head and empties
// the queue and output stage. When the receiver stalls, the output holds,
// the queue fills, and s_tready drops.
`include "frame_escape_xor_checksum_defines.svh"
module frame_escape_xor_checksum import fexc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // frame_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // frame_end
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    fexc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    fexc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (q_pop),
        .full    (q_full),
        .q_rd    (q_rd)
    );

    fexc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `FEXC_ASSERT_IMPLY(a_frame_end_flag, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == FLAG_BYTE))
    `FEXC_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, q_pop, q_rd.valid)
    `FEXC_ASSERT_IMPLY(a_push_not_full, aclk, aresetn, q_wr.push, !q_full)

endmodule
